[src/laplace_jacobi_relaxation_core_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the Laplace relaxation core
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef LAPLACE_JACOBI_RELAXATION_CORE_ASSERT_SVH
`define LAPLACE_JACOBI_RELAXATION_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LJR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LJR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// The expression must hold in every cycle.
`define LJR_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

`endif

[src/ljr_pkg.sv]
// ---------------------------------------------------------------------------
// Laplace relaxation core package
// Operation and register codes, controller states and the command and
// status groups between controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ljr_pkg;

    localparam int GS_W  = 7;
    localparam int TOL_W = 31;
    localparam int LIM_W = 24;
    localparam int OUT_W = 32;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_SOLVE = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [1:0] CFG_GRID_SIZE = 2'd0;
    localparam logic [1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [1:0] CFG_LIMIT     = 2'd2;

    // Sub-steps of one cell update: center, four neighbors, the final sum, then write back.
    localparam logic [2:0] STEP_CENTER = 3'd0;
    localparam logic [2:0] STEP_UP     = 3'd1;
    localparam logic [2:0] STEP_DOWN   = 3'd2;
    localparam logic [2:0] STEP_LEFT   = 3'd3;
    localparam logic [2:0] STEP_RIGHT  = 3'd4;
    localparam logic [2:0] STEP_SUM    = 3'd5;
    localparam logic [2:0] STEP_LAST   = 3'd6;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_THR_N,
        ST_THR_SQ,
        ST_THR_MUL,
        ST_CELL,
        ST_COPY,
        ST_DRAIN,
        ST_CHECK,
        ST_RESULT
    } ljr_state_t;

    typedef struct packed {
        logic clear_step;
        logic accept_write;
        logic accept_read;
        logic thr_n;
        logic thr_sq;
        logic thr_mul;
        logic sweep_start;
        logic cell_step;
        logic copy_issue;
        logic sweep_end;
        logic post_read;
        logic post_solve;
    } ljr_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic step_last;
        logic cell_last;
        logic limit_zero;
        logic limit_hit;
        logic converged_now;
        logic out_free;
    } ljr_status_t;

endpackage

`default_nettype wire

[src/ljr_ctrl.sv]
// ---------------------------------------------------------------------------
// Laplace relaxation controller
// Sequences clearing, item handling, sweeps, copy back and result posting.
// ---------------------------------------------------------------------------
`default_nettype none

module ljr_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [1:0]           operation,
    input  wire ljr_pkg::ljr_status_t status,
    output ljr_pkg::ljr_cmd_t         cmd
);
    import ljr_pkg::*;

    `include "laplace_jacobi_relaxation_core_assert.svh"

    ljr_state_t state_reg;
    ljr_state_t state_next;
    logic       accept;

    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && operation == OP_SOLVE)
                begin
                    state_next = ST_THR_N;
                end
                else if (accept && operation == OP_READ)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_THR_N:   state_next = ST_THR_SQ;
            ST_THR_SQ:  state_next = ST_THR_MUL;
            ST_THR_MUL: state_next = status.limit_zero ? ST_RESULT : ST_CELL;
            ST_CELL:
            begin
                if (status.step_last && status.cell_last)
                begin
                    state_next = ST_COPY;
                end
            end
            ST_COPY:
            begin
                if (status.cell_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (status.converged_now || status.limit_hit)
                begin
                    state_next = ST_RESULT;
                end
                else
                begin
                    state_next = ST_CELL;
                end
            end
            ST_RESULT:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            ST_CLEAR: cmd.clear_step = 1'b1;
            ST_IDLE:
            begin
                cmd.accept_write = accept && operation == OP_WRITE;
                cmd.accept_read  = accept && operation == OP_READ;
            end
            ST_READ:    cmd.post_read = status.out_free;
            ST_THR_N:   cmd.thr_n = 1'b1;
            ST_THR_SQ:  cmd.thr_sq = 1'b1;
            ST_THR_MUL:
            begin
                cmd.thr_mul     = 1'b1;
                cmd.sweep_start = !status.limit_zero;
            end
            ST_CELL:   cmd.cell_step = 1'b1;
            ST_COPY:   cmd.copy_issue = 1'b1;
            ST_DRAIN:  cmd.sweep_end = 1'b1;
            ST_CHECK:  cmd.sweep_start = !(status.converged_now || status.limit_hit);
            ST_RESULT: cmd.post_solve = status.out_free;
            default:   cmd = '0;
        endcase
    end

    `LJR_ASSERT_IMPL(a_post_needs_slot, cmd.post_read || cmd.post_solve, status.out_free,
        "result posted while the output register is still occupied")
    `LJR_ASSERT_NEXT(a_cell_to_copy,
        state_reg == ST_CELL && status.step_last && status.cell_last,
        state_reg == ST_COPY, "sweep end did not start the copy back")
    `LJR_ASSERT_ALWAYS(a_one_phase,
        $onehot0({cmd.clear_step, cmd.cell_step, cmd.copy_issue, cmd.accept_write}),
        "more than one memory phase active")
    `LJR_ASSERT_NEXT(a_clear_done, state_reg == ST_CLEAR && status.clear_last,
        state_reg == ST_IDLE, "clearing pass did not end in idle")

endmodule

`default_nettype wire

[src/ljr_dpath.sv]
// ---------------------------------------------------------------------------
// Laplace relaxation datapath
// Grid memories, configuration registers, cell update arithmetic, error
// accumulation and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module ljr_dpath #(
    parameter int GRID_MAX   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ljr_pkg::ljr_cmd_t     cmd,
    output ljr_pkg::ljr_status_t       status,
    input  wire logic [5:0]            row,
    input  wire logic [5:0]            column,
    input  wire logic signed [31:0]    cell_value,
    input  wire logic                  cell_fixed,
    input  wire logic                  cfg_valid,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         result_value,
    output logic [ljr_pkg::LIM_W-1:0]  sweeps_run,
    output logic                       converged
);
    import ljr_pkg::*;

    localparam int CW    = $clog2(GRID_MAX);
    localparam int AW_IX = 2 * CW;
    localparam int DEPTH = 1 << AW_IX;
    localparam int NB    = $clog2(GRID_MAX + 1);
    localparam int VB    = VALUE_BITS;
    localparam int SQ_W  = 2 * NB;
    localparam int TW    = TOL_W + SQ_W;
    localparam int DW    = VB + 1;
    localparam int ACW   = ((TW > DW) ? TW : DW) + 1;
    localparam int XW    = 32 + VB;
    localparam logic signed [XW-1:0] VMAX = {{33{1'b0}}, {(VB - 1){1'b1}}};
    localparam logic signed [XW-1:0] VMIN = ~VMAX;

    logic signed [VB-1:0] pot_mem  [DEPTH];
    logic signed [VB-1:0] next_mem [DEPTH];
    logic                 flag_mem [DEPTH];

    logic [GS_W-1:0]    grid_size_reg;
    logic [TOL_W-1:0]   tol_reg;
    logic [LIM_W-1:0]   lim_reg;
    logic [AW_IX-1:0]   clr_idx_reg;
    logic [NB-1:0]      n_reg;
    logic [SQ_W-1:0]    nsq_reg;
    logic [TW-1:0]      thr_reg;
    logic [CW-1:0]      r_reg;
    logic [CW-1:0]      c_reg;
    logic [2:0]         step_reg;
    logic               zero_reg;
    logic signed [VB+1:0] sum_reg;
    logic signed [VB-1:0] old_reg;
    logic               fix_reg;
    logic [ACW-1:0]     acc_reg;
    logic [LIM_W-1:0]   sweep_cnt_reg;
    logic signed [VB-1:0] pot_rdata_reg;
    logic signed [VB-1:0] next_rdata_reg;
    logic               flag_rdata_reg;
    logic               cp_pend_reg;
    logic [AW_IX-1:0]   cp_addr_reg;
    logic               rd_inside_reg;
    logic               out_valid_reg;
    logic signed [31:0] result_value_reg;
    logic [LIM_W-1:0]   sweeps_reg;
    logic               conv_reg;

    logic               item_inside;
    logic [AW_IX-1:0]   item_addr;
    logic signed [XW-1:0] in_wide;
    logic signed [VB-1:0] in_sat;
    logic [AW_IX-1:0]   center_addr;
    logic [AW_IX-1:0]   nb_addr;
    logic               nb_oob;
    logic               row_last;
    logic               col_last;
    logic               advance;
    logic signed [VB+1:0] nb_val;
    logic signed [VB+1:0] quarter;
    logic signed [VB-1:0] new_val;
    logic signed [VB:0]   diff;
    logic [DW-1:0]      abs_diff;
    logic [ACW-1:0]     acc_sum;
    logic [ACW-1:0]     acc_next;
    logic [NB-1:0]      n_next;
    logic               out_free;
    logic signed [XW-1:0] rd_wide;

    assign item_inside = (32'(row) < GRID_MAX) && (32'(column) < GRID_MAX);
    assign item_addr   = {CW'(row), CW'(column)};
    assign in_wide     = {{VB{cell_value[31]}}, cell_value};
    assign in_sat      = (in_wide > VMAX) ? VMAX[VB-1:0] :
                         (in_wide < VMIN) ? VMIN[VB-1:0] : in_wide[VB-1:0];

    assign center_addr = {r_reg, c_reg};
    assign row_last    = (32'(r_reg) + 1 == 32'(n_reg));
    assign col_last    = (32'(c_reg) + 1 == 32'(n_reg));
    assign advance     = (cmd.cell_step && step_reg == STEP_LAST) || cmd.copy_issue;

    // Neighbor address for the current sub-step; neighbors off the active
    // grid read as zero.
    always_comb
    begin
        nb_addr = center_addr;
        nb_oob  = 1'b0;
        case (step_reg)
            STEP_UP:
            begin
                nb_addr = {r_reg - 1'b1, c_reg};
                nb_oob  = (r_reg == '0);
            end
            STEP_DOWN:
            begin
                nb_addr = {r_reg + 1'b1, c_reg};
                nb_oob  = row_last;
            end
            STEP_LEFT:
            begin
                nb_addr = {r_reg, c_reg - 1'b1};
                nb_oob  = (c_reg == '0);
            end
            STEP_RIGHT:
            begin
                nb_addr = {r_reg, c_reg + 1'b1};
                nb_oob  = col_last;
            end
            default:
            begin
                nb_addr = center_addr;
                nb_oob  = 1'b0;
            end
        endcase
    end

    assign nb_val   = zero_reg ? '0 : (VB + 2)'(pot_rdata_reg);
    assign quarter  = sum_reg >>> 2;
    assign new_val  = fix_reg ? old_reg : quarter[VB-1:0];
    assign diff     = (VB + 1)'(new_val) - (VB + 1)'(old_reg);
    assign abs_diff = diff[VB] ? DW'(-diff) : DW'(diff);
    assign acc_sum  = acc_reg + ACW'(abs_diff);
    assign acc_next = (acc_sum >= ACW'(thr_reg)) ? ACW'(thr_reg) : acc_sum;

    assign n_next = (grid_size_reg < GS_W'(2)) ? NB'(2) :
                    (32'(grid_size_reg) > GRID_MAX) ? NB'(GRID_MAX) : NB'(grid_size_reg);

    assign out_free = !out_valid_reg || out_ready;
    assign rd_wide  = {{32{pot_rdata_reg[VB-1]}}, pot_rdata_reg};

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GS_W'(64);
            tol_reg       <= TOL_W'(2);
            lim_reg       <= '1;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GRID_SIZE: grid_size_reg <= cfg_data[GS_W-1:0];
                CFG_TOLERANCE: tol_reg <= cfg_data[TOL_W-1:0];
                CFG_LIMIT:     lim_reg <= cfg_data[LIM_W-1:0];
                default:       grid_size_reg <= grid_size_reg;
            endcase
        end
    end

    // Potential and flag memories: clearing pass, item writes, copy back.
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            pot_mem[clr_idx_reg]  <= '0;
            flag_mem[clr_idx_reg] <= 1'b0;
        end
        else if (cmd.accept_write && item_inside)
        begin
            pot_mem[item_addr]  <= in_sat;
            flag_mem[item_addr] <= cell_fixed;
        end
        else if (cp_pend_reg)
        begin
            pot_mem[cp_addr_reg] <= next_rdata_reg;
        end
        if (cmd.accept_read)
        begin
            pot_rdata_reg <= pot_mem[item_addr];
        end
        else if (cmd.cell_step)
        begin
            pot_rdata_reg <= pot_mem[nb_addr];
        end
        if (cmd.cell_step && step_reg == STEP_CENTER)
        begin
            flag_rdata_reg <= flag_mem[center_addr];
        end
    end

    // Scratch grid for the sweep in progress.
    always_ff @(posedge clk)
    begin
        if (cmd.cell_step && step_reg == STEP_LAST)
        begin
            next_mem[center_addr] <= new_val;
        end
        if (cmd.copy_issue)
        begin
            next_rdata_reg <= next_mem[center_addr];
        end
    end

    // Payload registers of the cell update and the threshold product.
    always_ff @(posedge clk)
    begin
        if (cmd.accept_read)
        begin
            rd_inside_reg <= item_inside;
        end
        if (cmd.thr_n)
        begin
            n_reg <= n_next;
        end
        if (cmd.thr_sq)
        begin
            nsq_reg <= n_reg * n_reg;
        end
        if (cmd.thr_mul)
        begin
            thr_reg <= tol_reg * nsq_reg;
        end
        if (cmd.copy_issue)
        begin
            cp_addr_reg <= center_addr;
        end
        if (cmd.cell_step)
        begin
            zero_reg <= nb_oob;
            case (step_reg)
                STEP_UP:
                begin
                    old_reg <= pot_rdata_reg;
                    fix_reg <= flag_rdata_reg;
                    sum_reg <= '0;
                end
                STEP_DOWN, STEP_LEFT, STEP_RIGHT, STEP_SUM:
                begin
                    sum_reg <= sum_reg + nb_val;
                end
                default:
                begin
                    sum_reg <= sum_reg;
                end
            endcase
        end
    end

    // Control counters and the output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg      <= '0;
            r_reg            <= '0;
            c_reg            <= '0;
            step_reg         <= STEP_CENTER;
            acc_reg          <= '0;
            sweep_cnt_reg    <= '0;
            cp_pend_reg      <= 1'b0;
            out_valid_reg    <= 1'b0;
            result_value_reg <= '0;
            sweeps_reg       <= '0;
            conv_reg         <= 1'b0;
        end
        else
        begin
            cp_pend_reg <= cmd.copy_issue;
            if (cmd.clear_step)
            begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
            end
            if (cmd.thr_n)
            begin
                sweep_cnt_reg <= '0;
                acc_reg       <= '0;
            end
            if (cmd.sweep_start)
            begin
                acc_reg  <= '0;
                r_reg    <= '0;
                c_reg    <= '0;
                step_reg <= STEP_CENTER;
            end
            else
            begin
                if (cmd.cell_step)
                begin
                    step_reg <= (step_reg == STEP_LAST) ? STEP_CENTER : step_reg + 3'd1;
                    if (step_reg == STEP_LAST)
                    begin
                        acc_reg <= acc_next;
                    end
                end
                if (advance)
                begin
                    c_reg <= col_last ? '0 : c_reg + 1'b1;
                    if (col_last)
                    begin
                        r_reg <= row_last ? '0 : r_reg + 1'b1;
                    end
                end
            end
            if (cmd.sweep_end)
            begin
                sweep_cnt_reg <= sweep_cnt_reg + 1'b1;
            end
            if (cmd.post_read)
            begin
                out_valid_reg    <= 1'b1;
                result_value_reg <= rd_inside_reg ? rd_wide[31:0] : '0;
                sweeps_reg       <= '0;
                conv_reg         <= 1'b0;
            end
            else if (cmd.post_solve)
            begin
                out_valid_reg    <= 1'b1;
                result_value_reg <= '0;
                sweeps_reg       <= sweep_cnt_reg;
                conv_reg         <= (sweep_cnt_reg != '0) && (acc_reg < ACW'(thr_reg));
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last    = (clr_idx_reg == AW_IX'(DEPTH - 1));
    assign status.step_last     = (step_reg == STEP_LAST);
    assign status.cell_last     = row_last && col_last;
    assign status.limit_zero    = (lim_reg == '0);
    assign status.limit_hit     = (sweep_cnt_reg == lim_reg);
    assign status.converged_now = (acc_reg < ACW'(thr_reg));
    assign status.out_free      = out_free;

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign sweeps_run   = sweeps_reg;
    assign converged    = conv_reg;

endmodule

`default_nettype wire

[src/laplace_jacobi_relaxation_core.sv]
// A cell write is taken in the idle state; a read result posts once the output register is free.
// A solve computes its threshold, then sweeps until it converges or reaches the limit, then posts.
// Each sweep is bound by the single read port of the potential memory: five reads per cell,
// then one copy-back read per cell from the scratch grid. One item is in work at a time.
// After reset a clearing pass zeroes the grid and flags, one entry a cycle over all
// 2^(2*ceil(log2(GRID_MAX))) entries (4096 by default); no item is taken until it ends.
// ---------------------------------------------------------------------------
// Laplace relaxation core
// Five-point Jacobi relaxation of the 2-D Laplace equation on a square grid
// of fixed-point potentials, with per-cell boundary flags.
// ---------------------------------------------------------------------------
`default_nettype none

module laplace_jacobi_relaxation_core #(
    parameter int GRID_MAX   = 64,
    parameter int VALUE_BITS = 32
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input item channel.
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0]            operation,
    input  wire logic [5:0]            row,
    input  wire logic [5:0]            column,
    input  wire logic signed [31:0]    cell_value,
    input  wire logic                  cell_fixed,
    // Result channel.
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         result_value,
    output logic [ljr_pkg::LIM_W-1:0]  sweeps_run,
    output logic                       converged,
    // Configuration write channel.
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [1:0]            cfg_index,
    input  wire logic [31:0]           cfg_data
);
    import ljr_pkg::*;

    ljr_cmd_t    cmd;
    ljr_status_t status;

    // Configuration is always taken, unchecked; the user must send transfers only while idle.
    assign cfg_ready = 1'b1;

    // The controller owns sequencing; the datapath owns every memory and counter.
    ljr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .operation (operation),
        .status    (status),
        .cmd       (cmd)
    );

    ljr_dpath #(
        .GRID_MAX   (GRID_MAX),
        .VALUE_BITS (VALUE_BITS)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .row          (row),
        .column       (column),
        .cell_value   (cell_value),
        .cell_fixed   (cell_fixed),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .sweeps_run   (sweeps_run),
        .converged    (converged)
    );

endmodule

`default_nettype wire
